// ===== rtl/sptx_pkg.sv =====
// ---------------------------------------------------------------------------
// sptx_pkg: shared types and constants of the single pixel serial transmitter
// Request payloads, the colour table and configuration register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package sptx_pkg;

    localparam int unsigned FrameBits  = 24;
    localparam int unsigned BitIdxW    = 5;
    localparam int unsigned CountW     = 16;
    localparam int unsigned PaddrW     = 4;
    localparam int unsigned PdataW     = 32;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_BIT_PERIOD   = 2'd0;
    localparam logic [1:0] REG_HIGH_ZERO    = 2'd1;
    localparam logic [1:0] REG_HIGH_ONE     = 2'd2;
    localparam logic [1:0] REG_GUARD_CYCLES = 2'd3;

    localparam logic [7:0]  BIT_PERIOD_RST   = 8'd24;
    localparam logic [7:0]  HIGH_ZERO_RST    = 8'd7;
    localparam logic [7:0]  HIGH_ONE_RST     = 8'd16;
    localparam logic [15:0] GUARD_CYCLES_RST = 16'd7200;

    // Colour names
    localparam logic [3:0] NAME_RED     = 4'd0;
    localparam logic [3:0] NAME_GREEN   = 4'd1;
    localparam logic [3:0] NAME_BLUE    = 4'd2;
    localparam logic [3:0] NAME_YELLOW  = 4'd3;
    localparam logic [3:0] NAME_ORANGE  = 4'd4;
    localparam logic [3:0] NAME_CYAN    = 4'd5;
    localparam logic [3:0] NAME_MAGENTA = 4'd6;
    localparam logic [3:0] NAME_PURPLE  = 4'd7;
    localparam logic [3:0] NAME_PINK    = 4'd8;
    localparam logic [3:0] NAME_WHITE   = 4'd9;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic       state_write;
        logic       state_level;
        logic       color_write;
        logic       use_name;
        logic [3:0] color_name;
        logic [7:0] brightness;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic data_line;
        logic busy_res;
    } out_item_t;

    function automatic rgb_t named_rgb(input logic [3:0] name);
        rgb_t c;
        c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
        case (name)
            NAME_RED:     c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            NAME_GREEN:   c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            NAME_BLUE:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            NAME_YELLOW:  c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            NAME_ORANGE:  c = '{red: 8'd255, green: 8'd80,  blue: 8'd0};
            NAME_CYAN:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
            NAME_MAGENTA: c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            NAME_PURPLE:  c = '{red: 8'd128, green: 8'd0,   blue: 8'd255};
            NAME_PINK:    c = '{red: 8'd255, green: 8'd40,  blue: 8'd70};
            NAME_WHITE:   c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            default:      c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sptx_in_if.sv =====
// ---------------------------------------------------------------------------
// sptx_in_if: input request channel
// Valid/ready channel carrying one tick request of the transmitter.
// ---------------------------------------------------------------------------
`default_nettype none

interface sptx_in_if;
    logic               valid;
    logic               ready;
    sptx_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sptx_out_if.sv =====
// ---------------------------------------------------------------------------
// sptx_out_if: result channel
// Valid/ready channel carrying the line level and busy flag of one tick.
// ---------------------------------------------------------------------------
`default_nettype none

interface sptx_out_if;
    logic                valid;
    logic                ready;
    sptx_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sptx_color_scale.sv =====
// ---------------------------------------------------------------------------
// sptx_color_scale: named colour lookup and brightness scaling
// Each component becomes (c * (brightness + 1)) >> 8.
// ---------------------------------------------------------------------------
`default_nettype none

module sptx_color_scale (
    input  wire logic [3:0]    color_name,
    input  wire logic [7:0]    brightness,
    output sptx_pkg::rgb_t     scaled
);
    import sptx_pkg::*;

    rgb_t        base;
    logic [8:0]  scale;
    logic [16:0] prod_r;
    logic [16:0] prod_g;
    logic [16:0] prod_b;

    assign base   = named_rgb(color_name);
    assign scale  = {1'b0, brightness} + 9'd1;
    assign prod_r = {9'b0, base.red} * {8'b0, scale};
    assign prod_g = {9'b0, base.green} * {8'b0, scale};
    assign prod_b = {9'b0, base.blue} * {8'b0, scale};

    assign scaled = '{red: prod_r[15:8], green: prod_g[15:8], blue: prod_b[15:8]};

endmodule

`default_nettype wire

// ===== rtl/single_pixel_ws2812_transmitter.sv =====
// ---------------------------------------------------------------------------
// single_pixel_ws2812_transmitter: one-pixel serial LED line encoder
// Each request on in_ch is one tick of the bit timer. A tick may write the
// lit state, a raw colour or a named colour with brightness; a state write,
// or a colour write while lit, starts a frame: guard_cycles low ticks, then
// 24 bits green, red, blue, most significant bit first.
// Every accepted request yields exactly one result on out_ch carrying the
// line level and the busy flag of that tick. The result is held in a single
// output register and appears in the cycle after acceptance. One request is
// taken every cycle; the limit is the output register, which frees up in the
// same cycle that its result is taken, so in_ch stalls only while out_ch does.
// A trigger during a frame is held as a pending request and a fresh frame
// follows once the current one ends.
// Timing registers are written through the APB port; the user must write them only
// while the channel is idle, which the block does not enforce. Reads return the
// current values. Reset restores the default timing, the default colour (green 40,
// red 40, blue 0), the off state and an idle line, and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module single_pixel_ws2812_transmitter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sptx_in_if.sink                            in_ch,
    sptx_out_if.source                         out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sptx_pkg::PaddrW-1:0]   paddr,
    input  wire logic [sptx_pkg::PdataW-1:0]   pwdata,
    output logic      [sptx_pkg::PdataW-1:0]   prdata,
    output logic                               pready
);
    import sptx_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_GUARD = 3'b010,
        PH_BITS  = 3'b100
    } phase_t;

    // Configuration
    logic [7:0]  bit_period_reg;
    logic [7:0]  high_zero_reg;
    logic [7:0]  high_one_reg;
    logic [15:0] guard_cycles_reg;
    logic        cfg_write;
    logic [1:0]  reg_idx;

    // Block state
    rgb_t                 color_reg;
    rgb_t                 color_next;
    logic                 lit_reg;
    logic                 lit_next;
    logic [FrameBits-1:0] shift_reg;
    logic [FrameBits-1:0] shift_next;
    logic [BitIdxW-1:0]   bidx_reg;
    logic [BitIdxW-1:0]   bidx_next;
    logic [CountW-1:0]    cnt_reg;
    logic [CountW-1:0]    cnt_next;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic                 pend_reg;
    logic                 pend_next;

    // Result register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    // Working signals
    in_item_t             req;
    logic                 accept;
    rgb_t                 named;
    logic                 trig;
    logic                 start;
    logic [FrameBits-1:0] content;
    phase_t               start_phase;
    phase_t               ph_e;
    logic [FrameBits-1:0] shift_e;
    logic [CountW-1:0]    cnt_e;
    logic [BitIdxW-1:0]   bidx_e;
    logic [CountW:0]      cnt_inc;
    logic [7:0]           per;
    logic [7:0]           hi;
    logic [BitIdxW-1:0]   bidx_inc;

    // -----------------------------------------------------------------------
    // APB register file
    // -----------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg   <= BIT_PERIOD_RST;
            high_zero_reg    <= HIGH_ZERO_RST;
            high_one_reg     <= HIGH_ONE_RST;
            guard_cycles_reg <= GUARD_CYCLES_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_BIT_PERIOD:   bit_period_reg   <= pwdata[7:0];
                REG_HIGH_ZERO:    high_zero_reg    <= pwdata[7:0];
                REG_HIGH_ONE:     high_one_reg     <= pwdata[7:0];
                REG_GUARD_CYCLES: guard_cycles_reg <= pwdata[15:0];
                default:          bit_period_reg   <= bit_period_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BIT_PERIOD:   prdata = {24'b0, bit_period_reg};
            REG_HIGH_ZERO:    prdata = {24'b0, high_zero_reg};
            REG_HIGH_ONE:     prdata = {24'b0, high_one_reg};
            REG_GUARD_CYCLES: prdata = {16'b0, guard_cycles_reg};
            default:          prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Handshake
    // -----------------------------------------------------------------------
    assign req          = in_ch.data;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    sptx_color_scale u_scale (
        .color_name (req.color_name),
        .brightness (req.brightness),
        .scaled     (named)
    );

    // -----------------------------------------------------------------------
    // One tick of the encoder
    // -----------------------------------------------------------------------
    always_comb
    begin
        lit_next   = req.state_write ? req.state_level : lit_reg;
        color_next = color_reg;
        if (req.color_write)
        begin
            if (req.use_name)
            begin
                color_next = named;
            end
            else
            begin
                color_next = '{red: req.red, green: req.green, blue: req.blue};
            end
        end
        trig = req.state_write || (req.color_write && lit_next);

        content     = lit_next ? {color_next.green, color_next.red, color_next.blue}
                               : '0;
        start_phase = (guard_cycles_reg == '0) ? PH_BITS : PH_GUARD;

        // A trigger on an idle line starts the frame within this very tick.
        start     = trig && (phase_reg == PH_IDLE);
        pend_next = pend_reg || (trig && (phase_reg != PH_IDLE));
        ph_e      = start ? start_phase : phase_reg;
        shift_e   = start ? content : shift_reg;
        cnt_e     = start ? '0 : cnt_reg;
        bidx_e    = start ? '0 : bidx_reg;

        cnt_inc  = {1'b0, cnt_e} + {{CountW{1'b0}}, 1'b1};
        per      = (bit_period_reg == '0) ? 8'd1 : bit_period_reg;
        hi       = shift_e[FrameBits-1] ? high_one_reg : high_zero_reg;
        bidx_inc = bidx_e + {{(BitIdxW-1){1'b0}}, 1'b1};

        phase_next    = ph_e;
        shift_next    = shift_e;
        cnt_next      = cnt_e;
        bidx_next     = bidx_e;
        out_data_next = '{data_line: 1'b0, busy_res: 1'b0};

        unique case (ph_e)
            PH_GUARD:
            begin
                out_data_next.busy_res = 1'b1;
                if (cnt_inc >= {1'b0, guard_cycles_reg})
                begin
                    phase_next = PH_BITS;
                    cnt_next   = '0;
                    bidx_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_inc[CountW-1:0];
                end
            end
            PH_BITS:
            begin
                out_data_next.busy_res  = 1'b1;
                out_data_next.data_line = (cnt_e < {8'b0, hi});
                if (cnt_inc >= {9'b0, per})
                begin
                    cnt_next   = '0;
                    shift_next = {shift_e[FrameBits-2:0], 1'b0};
                    bidx_next  = bidx_inc;
                    if (bidx_inc >= BitIdxW'(FrameBits))
                    begin
                        bidx_next  = '0;
                        phase_next = PH_IDLE;
                        if (pend_next)
                        begin
                            // Queued trigger: new frame with the current content.
                            pend_next  = 1'b0;
                            shift_next = content;
                            phase_next = start_phase;
                        end
                    end
                end
                else
                begin
                    cnt_next = cnt_inc[CountW-1:0];
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '{red: 8'd40, green: 8'd40, blue: 8'd0};
            lit_reg   <= 1'b0;
            shift_reg <= '0;
            bidx_reg  <= '0;
            cnt_reg   <= '0;
            phase_reg <= PH_IDLE;
            pend_reg  <= 1'b0;
        end
        else if (accept)
        begin
            color_reg <= color_next;
            lit_reg   <= lit_next;
            shift_reg <= shift_next;
            bidx_reg  <= bidx_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
